>>> src/wufr_pkg.sv
// ----------------------------------------------------------------------------
// wufr_pkg
// Shared types and constants of the weighted union-find ratio block.
// ----------------------------------------------------------------------------
package wufr_pkg;

  localparam int unsigned NODES_DEF     = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NODE_W        = 6;
  localparam int unsigned RATIO_W       = 32;

  typedef enum logic [0:0] {
    OP_UNION = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SEEN_WR_A, S_SEEN_WR_B, S_SEEN_RD_A, S_SEEN_RD_B,
    S_SEEN_CHK, S_FIND, S_WALK_RD, S_WALK_STEP, S_UNW_RD, S_UNW_MUL, S_UNW_WR,
    S_RAT_A, S_RAT_B, S_DECIDE, S_LINK_MUL, S_LINK_DIV, S_Q_DIV, S_DIV_WAIT,
    S_LINK_WR, S_OUT
  } state_e;

  typedef enum logic [4:0] {
    DP_NOP, DP_CLEAR, DP_LOAD, DP_SEEN_WR, DP_RD, DP_LATCH_B, DP_FIND, DP_WALK_RD,
    DP_WALK_STEP, DP_UNW_RD, DP_UNW_MUL, DP_UNW_WR, DP_LINK_MUL, DP_DIV_LINK,
    DP_DIV_QUERY, DP_LINK_WR, DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_b;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_range;
    logic is_query;
    logic seen_ok;
    logic walk_root;
    logic unw_empty;
    logic same_root;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> src/wufr_in_if.sv
// ----------------------------------------------------------------------------
// wufr_in_if
// Request channel: operation, two node indexes and a ratio.
// ----------------------------------------------------------------------------
interface wufr_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [wufr_pkg::NODE_W-1:0]     node_a;
  logic [wufr_pkg::NODE_W-1:0]     node_b;
  logic [wufr_pkg::RATIO_W-1:0]    ratio;

  modport source (output valid, operation, node_a, node_b, ratio, input ready);
  modport sink (input valid, operation, node_a, node_b, ratio, output ready);
endinterface

>>> src/wufr_out_if.sv
// ----------------------------------------------------------------------------
// wufr_out_if
// Response channel: quotient with found and saturated flags.
// ----------------------------------------------------------------------------
interface wufr_out_if;
  logic                            valid;
  logic                            ready;
  logic [wufr_pkg::RATIO_W-1:0]    quotient;
  logic                            found;
  logic                            saturated;

  modport source (output valid, quotient, found, saturated, input ready);
  modport sink (input valid, quotient, found, saturated, output ready);
endinterface

>>> src/wufr_div.sv
// ----------------------------------------------------------------------------
// wufr_div
// Restoring divider, one quotient bit per cycle, rounded half up and
// saturated to 32 bits.
// ----------------------------------------------------------------------------
module wufr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic        sat_o
);

  logic        run_q, fin_q, done_q, sat_q;
  logic [6:0]  cnt_q;
  logic [32:0] rem_q;
  logic [63:0] quo_q;
  logic [31:0] den_q, res_q;
  logic [32:0] rem_sh;
  logic        ge, round_up, sat;

  assign rem_sh   = {rem_q[31:0], quo_q[63]};
  assign ge       = rem_sh >= {1'b0, den_q};
  assign round_up = {rem_q, 1'b0} >= {2'b00, den_q};
  assign sat      = (den_q == '0) || (quo_q[63:32] != '0) || ((&quo_q[31:0]) && round_up);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 7'd64;
      end else if (run_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[62:0], ge};
    end
    if (fin_q) begin
      sat_q <= sat;
      res_q <= sat ? '1 : (quo_q[31:0] + {31'b0, round_up});
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;
  assign sat_o  = sat_q;

endmodule

>>> src/wufr_ctrl.sv
// ----------------------------------------------------------------------------
// wufr_ctrl
// Sequencer: clear pass, seen marking, two finds with path compression,
// link or query divide, response transfer.
// ----------------------------------------------------------------------------
module wufr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wufr_pkg::sts_t    sts_i,
  output wufr_pkg::cmd_t    cmd_o,
  output wufr_pkg::state_e  state_o
);

  wufr_pkg::state_e state_q, state_d;
  logic second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wufr_pkg::S_CLEAR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    second_d     = second_q;
    cmd_o.op     = wufr_pkg::DP_NOP;
    cmd_o.sel_b  = 1'b0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      wufr_pkg::S_CLEAR: begin
        cmd_o.op = wufr_pkg::DP_CLEAR;
        if (sts_i.clear_last) state_d = wufr_pkg::S_IDLE;
      end
      wufr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = wufr_pkg::DP_LOAD;
          second_d = 1'b0;
          state_d  = wufr_pkg::S_CHECK;
        end
      end
      wufr_pkg::S_CHECK: begin
        priority if (!sts_i.in_range)
          state_d = sts_i.is_query ? wufr_pkg::S_OUT : wufr_pkg::S_IDLE;
        else if (sts_i.is_query) state_d = wufr_pkg::S_SEEN_RD_A;
        else state_d = wufr_pkg::S_SEEN_WR_A;
      end
      wufr_pkg::S_SEEN_WR_A: begin
        cmd_o.op = wufr_pkg::DP_SEEN_WR;
        state_d  = wufr_pkg::S_SEEN_WR_B;
      end
      wufr_pkg::S_SEEN_WR_B: begin
        cmd_o.op    = wufr_pkg::DP_SEEN_WR;
        cmd_o.sel_b = 1'b1;
        state_d     = wufr_pkg::S_FIND;
      end
      wufr_pkg::S_SEEN_RD_A: begin
        cmd_o.op = wufr_pkg::DP_RD;
        state_d  = wufr_pkg::S_SEEN_RD_B;
      end
      wufr_pkg::S_SEEN_RD_B: begin
        cmd_o.op    = wufr_pkg::DP_RD;
        cmd_o.sel_b = 1'b1;
        state_d     = wufr_pkg::S_SEEN_CHK;
      end
      wufr_pkg::S_SEEN_CHK: begin
        state_d = sts_i.seen_ok ? wufr_pkg::S_FIND : wufr_pkg::S_OUT;
      end
      wufr_pkg::S_FIND: begin
        cmd_o.op    = wufr_pkg::DP_FIND;
        cmd_o.sel_b = second_q;
        state_d     = wufr_pkg::S_WALK_RD;
      end
      wufr_pkg::S_WALK_RD: begin
        cmd_o.op = wufr_pkg::DP_WALK_RD;
        state_d  = wufr_pkg::S_WALK_STEP;
      end
      wufr_pkg::S_WALK_STEP: begin
        cmd_o.op = wufr_pkg::DP_WALK_STEP;
        state_d  = sts_i.walk_root ? wufr_pkg::S_UNW_RD : wufr_pkg::S_WALK_RD;
      end
      wufr_pkg::S_UNW_RD: begin
        priority if (!sts_i.unw_empty) begin
          cmd_o.op = wufr_pkg::DP_UNW_RD;
          state_d  = wufr_pkg::S_UNW_MUL;
        end else if (!second_q) begin
          second_d = 1'b1;
          state_d  = wufr_pkg::S_FIND;
        end else begin
          state_d = wufr_pkg::S_RAT_A;
        end
      end
      wufr_pkg::S_UNW_MUL: begin
        cmd_o.op = wufr_pkg::DP_UNW_MUL;
        state_d  = wufr_pkg::S_UNW_WR;
      end
      wufr_pkg::S_UNW_WR: begin
        cmd_o.op = wufr_pkg::DP_UNW_WR;
        state_d  = wufr_pkg::S_UNW_RD;
      end
      wufr_pkg::S_RAT_A: begin
        cmd_o.op = wufr_pkg::DP_RD;
        state_d  = wufr_pkg::S_RAT_B;
      end
      wufr_pkg::S_RAT_B: begin
        cmd_o.op    = wufr_pkg::DP_RD;
        cmd_o.sel_b = 1'b1;
        state_d     = wufr_pkg::S_DECIDE;
      end
      wufr_pkg::S_DECIDE: begin
        cmd_o.op = wufr_pkg::DP_LATCH_B;
        priority if (sts_i.is_query)
          state_d = sts_i.same_root ? wufr_pkg::S_Q_DIV : wufr_pkg::S_OUT;
        else
          state_d = sts_i.same_root ? wufr_pkg::S_IDLE : wufr_pkg::S_LINK_MUL;
      end
      wufr_pkg::S_LINK_MUL: begin
        cmd_o.op = wufr_pkg::DP_LINK_MUL;
        state_d  = wufr_pkg::S_LINK_DIV;
      end
      wufr_pkg::S_LINK_DIV: begin
        cmd_o.op = wufr_pkg::DP_DIV_LINK;
        state_d  = wufr_pkg::S_DIV_WAIT;
      end
      wufr_pkg::S_Q_DIV: begin
        cmd_o.op = wufr_pkg::DP_DIV_QUERY;
        state_d  = wufr_pkg::S_DIV_WAIT;
      end
      wufr_pkg::S_DIV_WAIT: begin
        if (sts_i.div_done)
          state_d = sts_i.is_query ? wufr_pkg::S_OUT : wufr_pkg::S_LINK_WR;
      end
      wufr_pkg::S_LINK_WR: begin
        cmd_o.op = wufr_pkg::DP_LINK_WR;
        state_d  = wufr_pkg::S_IDLE;
      end
      wufr_pkg::S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = wufr_pkg::DP_OUT_LOAD;
          state_d  = wufr_pkg::S_IDLE;
        end
      end
      default: state_d = wufr_pkg::S_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule

>>> src/wufr_dp.sv
// ----------------------------------------------------------------------------
// wufr_dp
// Datapath: parent, ratio, seen and walk memories, multiplier, divider and
// response register.
// ----------------------------------------------------------------------------
module wufr_dp #(
  parameter int unsigned NODES     = wufr_pkg::NODES_DEF,
  parameter int unsigned FRAC_BITS = wufr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wufr_pkg::cmd_t                cmd_i,
  output wufr_pkg::sts_t                sts_o,
  input  logic                          operation_i,
  input  logic [wufr_pkg::NODE_W-1:0]   node_a_i,
  input  logic [wufr_pkg::NODE_W-1:0]   node_b_i,
  input  logic [wufr_pkg::RATIO_W-1:0]  ratio_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wufr_pkg::RATIO_W-1:0]  quotient_o,
  output logic                          found_o,
  output logic                          saturated_o
);

  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;
  localparam logic [64:0] HALF  = 65'(1) << (FRAC_BITS - 1);

  logic [IW-1:0] parent_mem [NODES];
  logic [31:0]   ratio_mem  [NODES];
  logic          seen_mem   [NODES];
  logic [IW+31:0] walk_mem  [NODES];

  logic          query_q, inrange_q, seen_a_q, found_q, clip_q, out_valid_q;
  logic [IW-1:0] a_q, b_q, cur_q, root_q, ra_q, clr_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   ratio_in_q, prev_q, wa_q, wb_q, quo_q;
  logic          found_out_q, sat_out_q;
  logic [63:0]   prod_q;
  logic [IW-1:0] parent_rd_q;
  logic [31:0]   ratio_rd_q;
  logic          seen_rd_q;
  logic [IW+31:0] walk_rd_q;

  logic [IW-1:0] rd_addr, par_wa, par_wd, sel_node, wk_node;
  logic [31:0]   rat_wd, mul_x, mul_y, mul_res, wk_ratio;
  logic          par_we, rat_we, seen_we, seen_wd, walk_root, mul_sat;
  logic [64:0]   rnd;
  logic [64:0]   rnd_sh;
  logic          div_start, div_done, div_sat;
  logic [63:0]   div_num;
  logic [31:0]   div_den, div_quo;

  assign sel_node  = cmd_i.sel_b ? b_q : a_q;
  assign wk_node   = walk_rd_q[IW+31:32];
  assign wk_ratio  = walk_rd_q[31:0];
  assign walk_root = (parent_rd_q == cur_q) || (cnt_q == CW'(NODES));
  assign rd_addr   = (cmd_i.op == wufr_pkg::DP_WALK_RD) ? cur_q : sel_node;

  assign rnd     = {1'b0, prod_q} + HALF;
  assign rnd_sh  = rnd >> FRAC_BITS;
  assign mul_sat = rnd_sh[64:32] != '0;
  assign mul_res = mul_sat ? '1 : rnd_sh[31:0];

  assign mul_x = (cmd_i.op == wufr_pkg::DP_LINK_MUL) ? wb_q : wk_ratio;
  assign mul_y = (cmd_i.op == wufr_pkg::DP_LINK_MUL) ? ratio_in_q : prev_q;

  always_comb begin
    par_we  = 1'b0;
    rat_we  = 1'b0;
    seen_we = 1'b0;
    seen_wd = 1'b1;
    par_wa  = wk_node;
    par_wd  = root_q;
    rat_wd  = mul_res;
    unique case (cmd_i.op)
      wufr_pkg::DP_CLEAR: begin
        par_we  = 1'b1;
        rat_we  = 1'b1;
        seen_we = 1'b1;
        seen_wd = 1'b0;
        par_wa  = clr_q;
        par_wd  = clr_q;
        rat_wd  = ONE_Q;
      end
      wufr_pkg::DP_SEEN_WR: begin
        seen_we = 1'b1;
        par_wa  = sel_node;
      end
      wufr_pkg::DP_UNW_WR: begin
        par_we = 1'b1;
        rat_we = 1'b1;
      end
      wufr_pkg::DP_LINK_WR: begin
        par_we = 1'b1;
        rat_we = 1'b1;
        par_wa = ra_q;
        rat_wd = div_quo;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (par_we) parent_mem[par_wa] <= par_wd;
    if (rat_we) ratio_mem[par_wa] <= rat_wd;
    if (seen_we) seen_mem[par_wa] <= seen_wd;
    parent_rd_q <= parent_mem[rd_addr];
    ratio_rd_q  <= ratio_mem[rd_addr];
    seen_rd_q   <= seen_mem[rd_addr];
    if (cmd_i.op == wufr_pkg::DP_WALK_STEP && !walk_root)
      walk_mem[cnt_q[IW-1:0]] <= {cur_q, ratio_rd_q};
    if (cmd_i.op == wufr_pkg::DP_UNW_RD)
      walk_rd_q <= walk_mem[IW'(cnt_q - CW'(1))];
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      wufr_pkg::DP_LOAD: begin
        query_q    <= operation_i;
        a_q        <= IW'(node_a_i);
        b_q        <= IW'(node_b_i);
        ratio_in_q <= ratio_i;
        inrange_q  <= (32'(node_a_i) < NODES) && (32'(node_b_i) < NODES);
        found_q    <= 1'b0;
        clip_q     <= 1'b0;
      end
      wufr_pkg::DP_RD: begin
        if (cmd_i.sel_b) begin
          seen_a_q <= seen_rd_q;
          wa_q     <= ratio_rd_q;
        end
      end
      wufr_pkg::DP_LATCH_B: wb_q <= ratio_rd_q;
      wufr_pkg::DP_FIND: begin
        if (cmd_i.sel_b) ra_q <= root_q;
        cur_q <= sel_node;
        cnt_q <= '0;
      end
      wufr_pkg::DP_WALK_STEP: begin
        if (walk_root) begin
          root_q <= cur_q;
          prev_q <= ratio_rd_q;
        end else begin
          cnt_q <= cnt_q + CW'(1);
          cur_q <= parent_rd_q;
        end
      end
      wufr_pkg::DP_UNW_RD: cnt_q <= cnt_q - CW'(1);
      wufr_pkg::DP_UNW_MUL, wufr_pkg::DP_LINK_MUL: prod_q <= 64'(mul_x) * 64'(mul_y);
      wufr_pkg::DP_UNW_WR: begin
        prev_q <= mul_res;
        if (mul_sat) clip_q <= 1'b1;
      end
      wufr_pkg::DP_DIV_QUERY: found_q <= 1'b1;
      default: ;
    endcase
    if (div_done && div_sat) clip_q <= 1'b1;
    if (cmd_i.op == wufr_pkg::DP_OUT_LOAD) begin
      quo_q       <= found_q ? div_quo : '0;
      found_out_q <= found_q;
      sat_out_q   <= clip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      if (cmd_i.op == wufr_pkg::DP_CLEAR) clr_q <= clr_q + IW'(1);
      if (cmd_i.op == wufr_pkg::DP_OUT_LOAD) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign div_start = (cmd_i.op == wufr_pkg::DP_DIV_LINK) ||
                     (cmd_i.op == wufr_pkg::DP_DIV_QUERY);
  assign div_num   = (cmd_i.op == wufr_pkg::DP_DIV_LINK) ? prod_q
                                                         : ({32'b0, wa_q} << FRAC_BITS);
  assign div_den   = (cmd_i.op == wufr_pkg::DP_DIV_LINK) ? wa_q : wb_q;

  wufr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo),
    .sat_o  (div_sat)
  );

  assign sts_o.clear_last = clr_q == IW'(NODES - 1);
  assign sts_o.in_range   = inrange_q;
  assign sts_o.is_query   = query_q;
  assign sts_o.seen_ok    = seen_a_q && seen_rd_q;
  assign sts_o.walk_root  = walk_root;
  assign sts_o.unw_empty  = cnt_q == '0;
  assign sts_o.same_root  = ra_q == root_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign quotient_o  = quo_q;
  assign found_o     = found_out_q;
  assign saturated_o = sat_out_q;

endmodule

>>> src/weighted_union_find_ratio.sv
// ----------------------------------------------------------------------------
// weighted_union_find_ratio
// Weighted union-find over NODES nodes with unsigned fixed-point ratios.
// ----------------------------------------------------------------------------
// After reset the block clears its tables before it takes a request. One
// request is processed at a time. Each walked parent path costs a read and a
// step per node on the way up, then a read, a multiply and a write per node
// on the way back, and a link or a connected query also runs the bit-serial
// divider, which sets the rate. A query response sits in an output register,
// so the next request is taken while it waits.
module weighted_union_find_ratio #(
  parameter int unsigned NODES     = wufr_pkg::NODES_DEF,
  parameter int unsigned FRAC_BITS = wufr_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wufr_in_if.sink    req_i,
  wufr_out_if.source rsp_o
);

  wufr_pkg::cmd_t   cmd;
  wufr_pkg::sts_t   sts;
  wufr_pkg::state_e state;

  wufr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(req_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .state_o   (state)
  );

  wufr_dp #(
    .NODES    (NODES),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .operation_i(req_i.operation),
    .node_a_i   (req_i.node_a),
    .node_b_i   (req_i.node_b),
    .ratio_i    (req_i.ratio),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .quotient_o (rsp_o.quotient),
    .found_o    (rsp_o.found),
    .saturated_o(rsp_o.saturated)
  );

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.found || rsp_o.quotient == '0))
    else $error("quotient nonzero without found");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |-> state == wufr_pkg::S_DIV_WAIT)
    else $error("divider done outside wait");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == wufr_pkg::DP_OUT_LOAD |-> sts.out_free)
    else $error("response overwritten");

endmodule
